### hdl/rpba_pkg.sv
// shared types and constants for the register pool bump allocator
// no dependencies; imported by rpba_pool and register_pool_bump_allocator
package rpba_pkg;

	localparam int POOL_SIZE       = 32;
	localparam int CLIENTS_DEFAULT = 4;

	localparam int OP_W     = 2;
	localparam int CLIENT_W = 3;
	localparam int OFF_W    = 5;
	localparam int LEN_W    = 6;
	// start + length of one region
	localparam int END_W    = 6;
	// sum of up to eight lengths
	localparam int USED_W   = LEN_W + 3;
	// width for fit and range checks against the pool size
	localparam int CMP_W    = USED_W;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_COMPACT = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_EXHAUSTED = 2'd2
	} status_t;

	// update request from the decode logic to the region table
	typedef struct packed {
		logic                alloc;
		logic                release_rgn;
		logic                compact;
		logic [CLIENT_W-1:0] client;
		logic [LEN_W-1:0]    size;
		logic [OFF_W-1:0]    base;
	} pool_cmd_t;

	// summaries of the region table
	typedef struct packed {
		logic [END_W-1:0]  top;
		logic [USED_W-1:0] used_next;
	} pool_sum_t;

endpackage

### hdl/rpba_pool.sv
// region table: per-client live flag, start and length, with update and compaction
// depends on rpba_pkg
module rpba_pool import rpba_pkg::*; #(
	parameter int CLIENTS = CLIENTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pool_cmd_t cmd,
	output pool_sum_t sum
);

	localparam int CID_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

	logic [CLIENTS-1:0] live_q;
	logic [OFF_W-1:0]   start_q [CLIENTS];
	logic [LEN_W-1:0]   len_q   [CLIENTS];

	logic [CLIENTS-1:0] live_n;
	logic [OFF_W-1:0]   start_n [CLIENTS];
	logic [LEN_W-1:0]   len_n   [CLIENTS];
	logic [USED_W-1:0]  pos     [CLIENTS];
	logic [CID_W-1:0]   idx;
	logic [END_W-1:0]   top_c;
	logic [USED_W-1:0]  used_c;

	assign idx = cmd.client[CID_W-1:0];
	assign sum = '{top: top_c, used_next: used_c};

	// highest end over the live regions
	always_comb begin
		logic [END_W-1:0] end_v;
		top_c = '0;
		for (int i = 0; i < CLIENTS; i++) begin
			end_v = END_W'(start_q[i]) + END_W'(len_q[i]);
			if (live_q[i] && end_v > top_c)
				top_c = end_v;
		end
	end

	// packed position: lengths of live regions ahead by offset, ties by client number
	always_comb begin
		for (int i = 0; i < CLIENTS; i++) begin
			pos[i] = '0;
			for (int j = 0; j < CLIENTS; j++) begin
				if (j != i && live_q[j] &&
				    (start_q[j] < start_q[i] || (start_q[j] == start_q[i] && j < i)))
					pos[i] = pos[i] + USED_W'(len_q[j]);
			end
		end
	end

	always_comb begin
		live_n = live_q;
		for (int i = 0; i < CLIENTS; i++) begin
			start_n[i] = start_q[i];
			len_n[i]   = len_q[i];
			if (cmd.compact && live_q[i])
				start_n[i] = pos[i][OFF_W-1:0];
		end
		if (cmd.alloc) begin
			live_n[idx]  = 1'b1;
			start_n[idx] = cmd.base;
			len_n[idx]   = cmd.size;
		end else if (cmd.release_rgn) begin
			live_n[idx]  = 1'b0;
			start_n[idx] = '0;
			len_n[idx]   = '0;
		end
	end

	always_comb begin
		used_c = '0;
		for (int i = 0; i < CLIENTS; i++) begin
			if (live_n[i])
				used_c = used_c + USED_W'(len_n[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			for (int i = 0; i < CLIENTS; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
			end
		end else begin
			live_q <= live_n;
			for (int i = 0; i < CLIENTS; i++) begin
				start_q[i] <= start_n[i];
				len_q[i]   <= len_n[i];
			end
		end
	end

endmodule

### hdl/register_pool_bump_allocator.sv
// register pool bump allocator: request register, decode, region table, result register
// depends on rpba_pkg and rpba_pool
// start is taken into the request register stage, and done is high in the cycle after
// that stage, with the result held in the result register
// throughput: one request per cycle; busy is always low, the result register loads on
// every taken request, the region table updates every cycle, and the receiver cannot stall
// reset: asynchronous active low, all clients unallocated, no result pending
module register_pool_bump_allocator import rpba_pkg::*; #(
	parameter int CLIENTS = CLIENTS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     opcode,
	input  logic [CLIENT_W-1:0] client_id,
	input  logic [LEN_W-1:0]    request_size,
	output logic                done,
	output logic [1:0]          status,
	output logic [OFF_W-1:0]    region_offset,
	output logic [LEN_W-1:0]    used_total,
	output logic [LEN_W-1:0]    free_total
);

	logic                req_valid_s1;
	op_t                 op_s1;
	logic [CLIENT_W-1:0] client_s1;
	logic [LEN_W-1:0]    size_s1;

	pool_cmd_t cmd;
	pool_sum_t sum;
	status_t   st;
	logic      client_ok;
	logic      size_ok;
	logic      fits;

	logic                done_q;
	status_t             status_q;
	logic [OFF_W-1:0]    offset_q;
	logic [LEN_W-1:0]    used_q;
	logic [LEN_W-1:0]    free_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_valid_s1 <= 1'b0;
		else
			req_valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1     <= op_t'(opcode);
			client_s1 <= client_id;
			size_s1   <= request_size;
		end
	end

	assign client_ok = CMP_W'(client_s1) < CMP_W'(CLIENTS);
	assign size_ok   = size_s1 != '0 && CMP_W'(size_s1) <= CMP_W'(POOL_SIZE);
	assign fits      = CMP_W'(sum.top) + CMP_W'(size_s1) <= CMP_W'(POOL_SIZE);

	always_comb begin
		cmd             = '0;
		cmd.client      = client_s1;
		cmd.size        = size_s1;
		cmd.base        = sum.top[OFF_W-1:0];
		st              = ST_OK;
		case (op_s1)
			OP_ALLOC: begin
				if (!client_ok || !size_ok)
					st = ST_INVALID;
				else if (!fits)
					st = ST_EXHAUSTED;
				else
					cmd.alloc = req_valid_s1;
			end
			OP_FREE: begin
				if (!client_ok)
					st = ST_INVALID;
				else
					cmd.release_rgn = req_valid_s1;
			end
			OP_COMPACT: cmd.compact = req_valid_s1;
			OP_QUERY:   st = ST_OK;
			default:    st = ST_OK;
		endcase
	end

	rpba_pool #(
		.CLIENTS(CLIENTS)
	) u_pool (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sum   (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= req_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			status_q <= st;
			offset_q <= cmd.alloc ? cmd.base : '0;
			used_q   <= sum.used_next[LEN_W-1:0];
			if (sum.used_next > USED_W'(POOL_SIZE))
				free_q <= '0;
			else
				free_q <= LEN_W'(USED_W'(POOL_SIZE) - sum.used_next);
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign region_offset = offset_q;
	assign used_total    = used_q;
	assign free_total    = free_q;

endmodule

### tb/tb_register_pool_bump_allocator.sv
`timescale 1ns / 100ps
// self-checking testbench for register_pool_bump_allocator: directed table, then random requests
// depends on rpba_pkg and the register_pool_bump_allocator rtl
module tb_register_pool_bump_allocator;
	import rpba_pkg::*;

	localparam int N_CLIENTS = CLIENTS_DEFAULT;
	localparam int RANDOM_BEATS = 1500;

	typedef struct packed {
		status_t           st;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  used;
		logic [LEN_W-1:0]  spare;
	} pool_reply_t;

	typedef struct packed {
		op_t                 op;
		logic [CLIENT_W-1:0] cid;
		logic [LEN_W-1:0]    sz;
		logic                pinned;
		pool_reply_t         reply;
	} script_row_t;

	localparam pool_reply_t NO_PIN = '{ST_OK, 5'd0, 6'd0, 6'd0};
	localparam int SCRIPT_LEN = 25;

	// fixed replies only where they are obvious; the rest goes through the predictor
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_QUERY,   3'd0, 6'd0,  1'b1, '{ST_OK,        5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd0, 6'd0,  1'b1, '{ST_INVALID,   5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd4, 6'd5,  1'b1, '{ST_INVALID,   5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd7, 6'd63, 1'b1, '{ST_INVALID,   5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd1, 6'd33, 1'b1, '{ST_INVALID,   5'd0, 6'd0,  6'd32}},
		'{OP_FREE,    3'd5, 6'd0,  1'b1, '{ST_INVALID,   5'd0, 6'd0,  6'd32}},
		'{OP_FREE,    3'd2, 6'd0,  1'b1, '{ST_OK,        5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd0, 6'd32, 1'b1, '{ST_OK,        5'd0, 6'd32, 6'd0}},
		'{OP_ALLOC,   3'd1, 6'd1,  1'b1, '{ST_EXHAUSTED, 5'd0, 6'd32, 6'd0}},
		'{OP_COMPACT, 3'd7, 6'd63, 1'b1, '{ST_OK,        5'd0, 6'd32, 6'd0}},
		'{OP_QUERY,   3'd3, 6'd42, 1'b1, '{ST_OK,        5'd0, 6'd32, 6'd0}},
		'{OP_FREE,    3'd0, 6'd0,  1'b1, '{ST_OK,        5'd0, 6'd0,  6'd32}},
		'{OP_ALLOC,   3'd0, 6'd8,  1'b0, NO_PIN},
		'{OP_ALLOC,   3'd1, 6'd8,  1'b0, NO_PIN},
		'{OP_ALLOC,   3'd2, 6'd8,  1'b0, NO_PIN},
		'{OP_ALLOC,   3'd3, 6'd8,  1'b0, NO_PIN},
		'{OP_FREE,    3'd1, 6'd0,  1'b0, NO_PIN},
		// hole below the top does not help
		'{OP_ALLOC,   3'd1, 6'd9,  1'b0, NO_PIN},
		'{OP_COMPACT, 3'd0, 6'd0,  1'b0, NO_PIN},
		'{OP_ALLOC,   3'd1, 6'd8,  1'b0, NO_PIN},
		// live client asks again while the pool is full
		'{OP_ALLOC,   3'd0, 6'd4,  1'b0, NO_PIN},
		'{OP_FREE,    3'd3, 6'd0,  1'b0, NO_PIN},
		'{OP_FREE,    3'd1, 6'd0,  1'b0, NO_PIN},
		// replacement lands above the old region
		'{OP_ALLOC,   3'd0, 6'd4,  1'b0, NO_PIN},
		'{OP_COMPACT, 3'd5, 6'd17, 1'b0, NO_PIN}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [OP_W-1:0]     opcode;
	logic [CLIENT_W-1:0] client_id;
	logic [LEN_W-1:0]    request_size;
	logic                done;
	logic [1:0]          status;
	logic [OFF_W-1:0]    region_offset;
	logic [LEN_W-1:0]    used_total;
	logic [LEN_W-1:0]    free_total;

	register_pool_bump_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.client_id    (client_id),
		.request_size (request_size),
		.done         (done),
		.status       (status),
		.region_offset(region_offset),
		.used_total   (used_total),
		.free_total   (free_total)
	);

	// predicted region table
	bit   region_live  [N_CLIENTS];
	int   region_base  [N_CLIENTS];
	int   region_len   [N_CLIENTS];

	pool_reply_t replies_due [$];
	int          errors;
	bit          pin_on;
	pool_reply_t pin_reply;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void apply_request(input op_t op, input logic [CLIENT_W-1:0] cid,
			input logic [LEN_W-1:0] sz, output pool_reply_t r);
		int top;
		int used;
		int pos;
		int c;
		int fresh [N_CLIENTS];
		r = NO_PIN;
		c = int'(cid);
		top = 0;
		for (int i = 0; i < N_CLIENTS; i++) begin
			if (region_live[i] && region_base[i] + region_len[i] > top)
				top = region_base[i] + region_len[i];
		end
		case (op)
			OP_ALLOC: begin
				if (c >= N_CLIENTS || sz == 0 || int'(sz) > POOL_SIZE)
					r.st = ST_INVALID;
				else if (top + int'(sz) > POOL_SIZE)
					r.st = ST_EXHAUSTED;
				else begin
					region_live[c] = 1'b1;
					region_base[c] = top;
					region_len[c]  = int'(sz);
					r.offset       = top[OFF_W-1:0];
				end
			end
			OP_FREE: begin
				if (c >= N_CLIENTS)
					r.st = ST_INVALID;
				else begin
					region_live[c] = 1'b0;
					region_base[c] = 0;
					region_len[c]  = 0;
				end
			end
			OP_COMPACT: begin
				// new base = total length of live regions ordered ahead; ties go to lower client
				for (int i = 0; i < N_CLIENTS; i++) begin
					pos = 0;
					for (int j = 0; j < N_CLIENTS; j++) begin
						if (j != i && region_live[j] && (region_base[j] < region_base[i] ||
								(region_base[j] == region_base[i] && j < i)))
							pos += region_len[j];
					end
					fresh[i] = region_live[i] ? pos : region_base[i];
				end
				for (int i = 0; i < N_CLIENTS; i++)
					region_base[i] = fresh[i];
			end
			default: ;
		endcase
		used = 0;
		for (int i = 0; i < N_CLIENTS; i++) begin
			if (region_live[i])
				used += region_len[i];
		end
		r.used  = used[LEN_W-1:0];
		r.spare = (used > POOL_SIZE) ? '0 : LEN_W'(POOL_SIZE - used);
	endfunction

	task automatic report_beat(input string what, input pool_reply_t want, input pool_reply_t got);
		if (errors < 10)
			$display("%0t %s: expected st=%0d off=%0d used=%0d free=%0d, %s",
				$realtime, what, want.st, want.offset, want.used, want.spare,
				$sformatf("got st=%0d off=%0d used=%0d free=%0d",
					got.st, got.offset, got.used, got.spare));
		errors++;
	endtask

	// result check first, then prediction for a newly taken request
	always @(posedge clk) begin : watch_beats
		pool_reply_t got;
		pool_reply_t want;
		if (arst_n) begin
			if (done) begin
				got.st     = status_t'(status);
				got.offset = region_offset;
				got.used   = used_total;
				got.spare  = free_total;
				if (replies_due.size() == 0)
					report_beat("unexpected result", NO_PIN, got);
				else begin
					want = replies_due.pop_front();
					if (got.st !== want.st || got.offset !== want.offset ||
							got.used !== want.used || got.spare !== want.spare)
						report_beat("result mismatch", want, got);
				end
			end
			if (start && !busy) begin
				apply_request(op_t'(opcode), client_id, request_size, want);
				if (pin_on)
					want = pin_reply;
				replies_due.push_back(want);
			end
		end
	end

	task automatic issue(input op_t op, input logic [CLIENT_W-1:0] cid,
			input logic [LEN_W-1:0] sz, input bit pinned, input pool_reply_t reply);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start        <= 1'b1;
		opcode       <= op;
		client_id    <= cid;
		request_size <= sz;
		pin_on        = pinned;
		pin_reply     = reply;
		do @(posedge clk); while (busy);
	endtask

	initial begin : stimulus
		int pick;
		op_t op;
		logic [CLIENT_W-1:0] cid;
		logic [LEN_W-1:0] sz;
		errors       = 0;
		pin_on       = 1'b0;
		pin_reply    = NO_PIN;
		no_idle      = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = OP_QUERY;
		client_id    = '0;
		request_size = '0;
		for (int i = 0; i < N_CLIENTS; i++) begin
			region_live[i] = 1'b0;
			region_base[i] = 0;
			region_len[i]  = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < SCRIPT_LEN; k++)
			issue(SCRIPT[k].op, SCRIPT[k].cid, SCRIPT[k].sz, SCRIPT[k].pinned, SCRIPT[k].reply);

		for (int k = 0; k < RANDOM_BEATS; k++) begin
			if (k % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (k == RANDOM_BEATS / 2) begin
				// drain the pipe before going on
				@(negedge clk);
				start <= 1'b0;
				while (replies_due.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			cid  = CLIENT_W'($urandom_range(0, 7));
			sz   = LEN_W'($urandom_range(0, 63));
			if (pick < 45) begin
				op = OP_ALLOC;
				if ($urandom_range(0, 9) != 0)
					cid = CLIENT_W'($urandom_range(0, N_CLIENTS - 1));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					sz = LEN_W'($urandom_range(1, 8));
				else if (pick < 85)
					sz = LEN_W'($urandom_range(1, POOL_SIZE));
				else if (pick < 95)
					sz = LEN_W'($urandom_range(POOL_SIZE + 1, 63));
				else
					sz = '0;
			end else if (pick < 70) begin
				op = OP_FREE;
				if ($urandom_range(0, 9) != 0)
					cid = CLIENT_W'($urandom_range(0, N_CLIENTS - 1));
			end else if (pick < 85)
				op = OP_COMPACT;
			else
				op = OP_QUERY;
			issue(op, cid, sz, 1'b0, NO_PIN);
		end

		@(negedge clk);
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
hdl/rpba_pkg.sv
hdl/rpba_pool.sv
hdl/register_pool_bump_allocator.sv
tb/tb_register_pool_bump_allocator.sv
